FILE: hw/rtl/pcwrl_pkg.sv
// -----------------------------------------------------------------------------
// pcwrl_pkg
// Shared types and constants for the per-client window rate limiter.
// -----------------------------------------------------------------------------
package pcwrl_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int OP_W       = 2;
   localparam int KEY_W      = 32;
   localparam int TIME_W     = 64;
   localparam int CNT_W      = 17;
   localparam int VERDICT_W  = 2;
   localparam int REMOVED_W  = 7;
   localparam int RATE_W     = 16;
   localparam int WIN_MS_W   = 24;
   localparam int NS_MS_W    = 20;
   localparam int WIN_NS_W   = WIN_MS_W + NS_MS_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [NS_MS_W-1:0] NS_PER_MS = NS_MS_W'(1000000);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 2'd3;

   // configuration reset values
   localparam logic                RST_ENABLED   = 1'b1;
   localparam logic [RATE_W-1:0]   RST_RATE      = RATE_W'(100);
   localparam logic [RATE_W-1:0]   RST_BURST     = RATE_W'(20);
   localparam logic [WIN_MS_W-1:0] RST_WINDOW_MS = WIN_MS_W'(1000);

   typedef enum logic [OP_W-1:0] {
      OP_CHECK   = 2'd0,
      OP_RESET   = 2'd1,
      OP_QUERY   = 2'd2,
      OP_CLEANUP = 2'd3
   } op_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_ALLOWED  = 2'd0,
      VERDICT_DENIED   = 2'd1,
      VERDICT_DISABLED = 2'd2,
      VERDICT_DONE     = 2'd3
   } verdict_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // latch request word, clear scan results
      logic scan_rd;  // read table entry at scan address, advance
      logic slot_rd;  // read selected slot
      logic eval;     // window expiry check on selected slot
      logic finish;   // commit table update, load result word
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hw/rtl/pcwrl_req_if.sv
// -----------------------------------------------------------------------------
// pcwrl_req_if
// Request channel: valid/ready handshake carrying one request word.
// -----------------------------------------------------------------------------
interface pcwrl_req_if;
   logic                          valid;
   logic                          ready;
   logic [pcwrl_pkg::OP_W-1:0]    operation;
   logic [pcwrl_pkg::KEY_W-1:0]   client_key;
   logic [pcwrl_pkg::TIME_W-1:0]  now_ns;

   modport source (output valid, output operation, output client_key, output now_ns,
                   input ready);
   modport sink   (input valid, input operation, input client_key, input now_ns,
                   output ready);
endinterface

FILE: hw/rtl/pcwrl_rsp_if.sv
// -----------------------------------------------------------------------------
// pcwrl_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// -----------------------------------------------------------------------------
interface pcwrl_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pcwrl_pkg::VERDICT_W-1:0] verdict;
   logic [pcwrl_pkg::CNT_W-1:0]     window_count;
   logic [pcwrl_pkg::REMOVED_W-1:0] removed_entries;

   modport source (output valid, output verdict, output window_count,
                   output removed_entries, input ready);
   modport sink   (input valid, input verdict, input window_count,
                   input removed_entries, output ready);
endinterface

FILE: hw/rtl/per_client_window_rate_limiter.sv
// -----------------------------------------------------------------------------
// per_client_window_rate_limiter
// Per-client fixed-window admission control over a 64-entry client table.
// -----------------------------------------------------------------------------
// Every request word walks the whole client table, one entry per cycle through
// the single read port of the key/count/timestamp memories, and the next word
// can be accepted only once this word has passed through the table scan, a
// drain state, a slot read, a window check and a commit. The result word is
// loaded into an output register at commit and is shown on rsp_chan the cycle
// after; the next request is taken while that result waits, and only the commit
// of the following word stalls if the result has still not been taken.
// Configuration writes are registered (the window also through its derived ns
// register) and should be made while no request is in flight.
module per_client_window_rate_limiter (
   input  logic                             clock,
   input  logic                             reset,
   pcwrl_req_if.sink                        req_chan,
   pcwrl_rsp_if.source                      rsp_chan,
   input  logic                             csr_we,
   input  logic [pcwrl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcwrl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pcwrl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pcwrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcwrl_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_chan.operation),
      .req_client_key      (req_chan.client_key),
      .req_now_ns          (req_chan.now_ns),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_verdict         (rsp_chan.verdict),
      .rsp_window_count    (rsp_chan.window_count),
      .rsp_removed_entries (rsp_chan.removed_entries),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

endmodule

FILE: hw/rtl/pcwrl_ctrl.sv
// -----------------------------------------------------------------------------
// pcwrl_ctrl
// Sequencer: accept, table scan, slot read, evaluate, commit.
// -----------------------------------------------------------------------------
module pcwrl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pcwrl_pkg::dp_status_type status,
   output pcwrl_pkg::ctrl_cmd_type  cmd
);
   import pcwrl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (status.scan_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_FINISH;
         ST_FINISH: if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.accept  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.scan_rd = (state_ff == ST_SCAN);
   assign cmd.slot_rd = (state_ff == ST_DECIDE);
   assign cmd.eval    = (state_ff == ST_EVAL);
   assign cmd.finish  = (state_ff == ST_FINISH) && status.out_free;

endmodule

FILE: hw/rtl/pcwrl_dpath.sv
// -----------------------------------------------------------------------------
// pcwrl_dpath
// Client table memories, scan compare, window arithmetic and result register.
// -----------------------------------------------------------------------------
module pcwrl_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pcwrl_pkg::ctrl_cmd_type              cmd,
   output pcwrl_pkg::dp_status_type             status,
   input  logic [pcwrl_pkg::OP_W-1:0]           req_operation,
   input  logic [pcwrl_pkg::KEY_W-1:0]          req_client_key,
   input  logic [pcwrl_pkg::TIME_W-1:0]         req_now_ns,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [pcwrl_pkg::VERDICT_W-1:0]      rsp_verdict,
   output logic [pcwrl_pkg::CNT_W-1:0]          rsp_window_count,
   output logic [pcwrl_pkg::REMOVED_W-1:0]      rsp_removed_entries,
   input  logic                                 csr_we,
   input  logic [pcwrl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcwrl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pcwrl_pkg::*;

   // configuration
   logic                enabled_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic [RATE_W-1:0]   burst_ff;
   logic [WIN_MS_W-1:0] win_ms_ff;
   logic [WIN_NS_W-1:0] window_ns_ff;
   logic [WIN_NS_W:0]   idle_limit;

   // request word
   op_type              op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [TIME_W-1:0]   now_ff;

   // table
   logic [KEY_W-1:0]    key_ram   [TABLE_ENTRIES];
   logic [CNT_W-1:0]    cnt_ram   [TABLE_ENTRIES];
   logic [TIME_W-1:0]   start_ram [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;

   // scan
   logic [IDX_W-1:0]    scan_addr_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_vld_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_rd;
   logic [KEY_W-1:0]    key_rd_ff;
   logic [CNT_W-1:0]    cnt_rd_ff;
   logic [TIME_W-1:0]   start_rd_ff;
   logic                hit_found_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic                free_found_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic [REMOVED_W-1:0] removed_ff;

   logic                ent_valid;
   logic                ent_hit;
   logic                ent_stale;
   logic [TIME_W-1:0]   elapsed;
   logic                sweep_clear;

   // evaluate / commit
   logic                restart_ff;
   logic [CNT_W-1:0]    base_cnt_ff;
   logic [IDX_W-1:0]    slot_idx;
   logic [CNT_W-1:0]    cnt_eff;
   logic [CNT_W-1:0]    limit;
   logic                allow;
   logic [CNT_W-1:0]    cnt_next;
   logic                key_we;
   logic                cnt_we;
   logic                start_we;
   logic [CNT_W-1:0]    cnt_wdata;
   logic                set_valid;
   verdict_type         verdict_in;
   logic [CNT_W-1:0]    count_in;
   logic [REMOVED_W-1:0] removed_in;

   // result register
   logic                rsp_valid_ff;
   logic [VERDICT_W-1:0] rsp_verdict_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic [REMOVED_W-1:0] rsp_removed_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= RST_ENABLED;
         rate_ff    <= RST_RATE;
         burst_ff   <= RST_BURST;
         win_ms_ff  <= RST_WINDOW_MS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLED: enabled_ff <= csr_wdata[0];
            CSR_RATE:    rate_ff    <= csr_wdata[RATE_W-1:0];
            CSR_BURST:   burst_ff   <= csr_wdata[RATE_W-1:0];
            CSR_WINDOW:  win_ms_ff  <= csr_wdata[WIN_MS_W-1:0];
            default:     ;
         endcase
      end
   end

   // window in ns, re-derived every cycle; ready long before its first use
   always_ff @(posedge clock) begin
      window_ns_ff <= WIN_NS_W'(win_ms_ff) * WIN_NS_W'(NS_PER_MS);
   end

   assign idle_limit = {window_ns_ff, 1'b0};

   // ---------------- request word ----------------
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= op_type'(req_operation);
         key_ff <= req_client_key;
         now_ff <= req_now_ns;
      end
   end

   // ---------------- table memories ----------------
   assign slot_idx = hit_found_ff ? hit_idx_ff : free_idx_ff;
   assign rd_addr  = cmd.slot_rd ? slot_idx : scan_addr_ff;
   assign mem_rd   = cmd.scan_rd || cmd.slot_rd;

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         key_rd_ff <= key_ram[rd_addr];
      end
      if (key_we) begin
         key_ram[slot_idx] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         cnt_rd_ff <= cnt_ram[rd_addr];
      end
      if (cnt_we) begin
         cnt_ram[slot_idx] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         start_rd_ff <= start_ram[rd_addr];
      end
      if (start_we) begin
         start_ram[slot_idx] <= now_ff;
      end
   end

   // ---------------- scan ----------------
   assign status.scan_last = (scan_addr_ff == IDX_W'(TABLE_ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_rd) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
      end
      if (cmd.scan_rd) begin
         rd_idx_ff <= scan_addr_ff;
      end
   end

   // entry read last cycle is compared this cycle
   assign ent_valid   = valid_ff[rd_idx_ff];
   assign ent_hit     = rd_vld_ff && ent_valid && (key_rd_ff == key_ff);
   assign elapsed     = now_ff - start_rd_ff;
   assign ent_stale   = ent_valid && (elapsed > TIME_W'(idle_limit));
   assign sweep_clear = rd_vld_ff && (op_ff == OP_CLEANUP) && ent_stale;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         removed_ff    <= '0;
      end else begin
         if (ent_hit && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= rd_idx_ff;
         end
         if (rd_vld_ff && !ent_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= rd_idx_ff;
         end
         if (sweep_clear) begin
            removed_ff <= removed_ff + 1'b1;
         end
      end
   end

   // ---------------- evaluate ----------------
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         restart_ff  <= hit_found_ff && (elapsed > TIME_W'(window_ns_ff));
         base_cnt_ff <= hit_found_ff ? cnt_rd_ff : '0;
      end
   end

   // ---------------- commit ----------------
   assign cnt_eff  = restart_ff ? '0 : base_cnt_ff;
   assign limit    = CNT_W'(rate_ff) + CNT_W'(burst_ff);
   assign allow    = (cnt_eff < limit);
   assign cnt_next = allow ? CNT_W'(cnt_eff + 1'b1) : cnt_eff;

   always_comb begin
      key_we     = 1'b0;
      cnt_we     = 1'b0;
      start_we   = 1'b0;
      set_valid  = 1'b0;
      cnt_wdata  = cnt_next;
      verdict_in = VERDICT_DONE;
      count_in   = '0;
      removed_in = '0;
      unique case (op_ff)
         OP_CHECK: begin
            if (!enabled_ff) begin
               verdict_in = VERDICT_DISABLED;
            end else if (hit_found_ff || free_found_ff) begin
               cnt_we     = cmd.finish;
               start_we   = cmd.finish && (restart_ff || !hit_found_ff);
               key_we     = cmd.finish && !hit_found_ff;
               set_valid  = cmd.finish && !hit_found_ff;
               verdict_in = allow ? VERDICT_ALLOWED : VERDICT_DENIED;
               count_in   = cnt_next;
            end else begin
               // table full, new key
               verdict_in = VERDICT_DENIED;
            end
         end
         OP_RESET: begin
            cnt_we    = cmd.finish && hit_found_ff;
            start_we  = cmd.finish && hit_found_ff;
            cnt_wdata = '0;
         end
         OP_QUERY: begin
            count_in = base_cnt_ff;
         end
         OP_CLEANUP: begin
            removed_in = removed_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (sweep_clear) begin
         valid_in[rd_idx_ff] = 1'b0;
      end
      if (set_valid) begin
         valid_in[slot_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------- result register ----------------
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_verdict_ff <= verdict_in;
         rsp_count_ff   <= count_in;
         rsp_removed_ff <= removed_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_window_count    = rsp_count_ff;
   assign rsp_removed_entries = rsp_removed_ff;

endmodule

FILE: dv/per_client_window_rate_limiter_tb.sv
// -----------------------------------------------------------------------------
// per_client_window_rate_limiter_tb
// Self-checking bench for the rate limiter. It sends check, reset, query and
// cleanup words under changing allowance and window settings. A local mirror
// of the client table predicts every result word, and each result is compared
// field by field in order of arrival.
// -----------------------------------------------------------------------------
module per_client_window_rate_limiter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pcwrl_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_WORDS  = 650;
   localparam int SETTLE_CYCLES = 2 * TABLE_ENTRIES + 16;
   localparam int KEY_MEMORY    = 80;

   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [TIME_W-1:0]  now;
   } request_word_type;

   typedef struct packed {
      verdict_type           verdict;
      logic [CNT_W-1:0]      count;
      logic [REMOVED_W-1:0]  removed;
   } verdict_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pcwrl_req_if req_if();
   pcwrl_rsp_if rsp_if();

   per_client_window_rate_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // mirror of the client table and the settings
   logic                 tbl_valid [TABLE_ENTRIES];
   logic [KEY_W-1:0]     tbl_key   [TABLE_ENTRIES];
   logic [CNT_W-1:0]     tbl_count [TABLE_ENTRIES];
   logic [TIME_W-1:0]    tbl_start [TABLE_ENTRIES];

   logic                 cfg_enabled;
   logic [RATE_W-1:0]    cfg_rate;
   logic [RATE_W-1:0]    cfg_burst;
   logic [WIN_MS_W-1:0]  cfg_window_ms;

   request_word_type     pending_requests[$];
   verdict_word_type     expected_verdicts[$];
   logic [KEY_W-1:0]     key_pool[$];

   int                   send_idle_pct;
   int                   recv_idle_pct;
   logic                 req_taken;
   int                   mismatches;
   int                   cycles;
   int                   words_queued;
   int                   words_seen;
   int                   settings_used;
   int                   denied_seen;
   int                   sweeps_seen;
   int                   removed_seen;
   logic [TIME_W-1:0]    clock_ns;

   function automatic logic [TIME_W-1:0] window_in_ns();
      return TIME_W'(cfg_window_ms) * TIME_W'(1000000);
   endfunction

   function automatic int find_client(logic [KEY_W-1:0] key);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (tbl_valid[i] && tbl_key[i] == key) return i;
      return -1;
   endfunction

   // Updates the mirror for one word and returns the result it should give.
   function automatic verdict_word_type judge_request(request_word_type w);
      verdict_word_type   v;
      int                 slot;
      logic [TIME_W-1:0]  span;
      logic [CNT_W-1:0]   limit;
      v.verdict = VERDICT_DONE;
      v.count   = '0;
      v.removed = '0;
      span      = window_in_ns();
      limit     = CNT_W'(cfg_rate) + CNT_W'(cfg_burst);
      case (w.op)
         OP_CHECK: begin
            if (!cfg_enabled) begin
               v.verdict = VERDICT_DISABLED;
            end else begin
               slot = find_client(w.key);
               if (slot < 0) begin
                  // new client takes the lowest free entry
                  for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                     if (!tbl_valid[i]) slot = i;
                  if (slot >= 0) begin
                     tbl_valid[slot] = 1'b1;
                     tbl_key[slot]   = w.key;
                     tbl_count[slot] = '0;
                     tbl_start[slot] = w.now;
                  end
               end
               if (slot < 0) begin
                  v.verdict = VERDICT_DENIED;
               end else begin
                  if (w.now - tbl_start[slot] > span) begin
                     tbl_count[slot] = '0;
                     tbl_start[slot] = w.now;
                  end
                  if (tbl_count[slot] >= limit) begin
                     v.verdict = VERDICT_DENIED;
                  end else begin
                     tbl_count[slot] = tbl_count[slot] + 1'b1;
                     v.verdict = VERDICT_ALLOWED;
                  end
                  v.count = tbl_count[slot];
               end
            end
         end
         OP_RESET: begin
            slot = find_client(w.key);
            if (slot >= 0) begin
               tbl_count[slot] = '0;
               tbl_start[slot] = w.now;
            end
         end
         OP_QUERY: begin
            slot = find_client(w.key);
            if (slot >= 0) v.count = tbl_count[slot];
         end
         default: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (tbl_valid[i] && w.now - tbl_start[i] > (span << 1)) begin
                  tbl_valid[i] = 1'b0;
                  v.removed = v.removed + 1'b1;
               end
            end
         end
      endcase
      return v;
   endfunction

   function automatic logic [RATE_W-1:0] pick_allowance();
      case ($urandom_range(5))
         0:       return '0;
         1:       return RATE_W'($urandom_range(1, 3));
         2:       return RATE_W'($urandom_range(4, 12));
         3:       return RATE_W'($urandom_range(13, 60));
         4:       return '1;
         default: return RATE_W'($urandom);
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] time_step();
      logic [TIME_W-1:0] span;
      span = window_in_ns();
      case ($urandom_range(9))
         0, 1, 2: return '0;
         3, 4:    return TIME_W'($urandom_range(1, 1000));
         5, 6:    return (span == 0) ? TIME_W'(1) : {$urandom, $urandom} % span;
         7:       return span;
         8:       return span + 1 + $urandom_range(0, 1000);
         default: return (span << 1) + 1 + $urandom_range(0, 1000);
      endcase
   endfunction

   task automatic queue_word(op_type op, logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
      request_word_type w;
      w.op  = op;
      w.key = key;
      w.now = now;
      pending_requests.push_back(w);
      words_queued++;
      if (op == OP_CHECK) begin
         key_pool.push_back(key);
         if (key_pool.size() > KEY_MEMORY) void'(key_pool.pop_front());
      end
   endtask

   // Wait until every word is sent and answered, then let the block go quiet.
   task automatic drain();
      while (pending_requests.size() != 0 || req_if.valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers; unused upper data bits carry random noise.
   task automatic apply_settings(logic en, logic [RATE_W-1:0] rate,
                                 logic [RATE_W-1:0] burst, logic [WIN_MS_W-1:0] win_ms);
      logic [CSR_IDX_W-1:0]  sel  [4];
      logic [CSR_DATA_W-1:0] data [4];
      sel[0]  = CSR_ENABLED;
      sel[1]  = CSR_RATE;
      sel[2]  = CSR_BURST;
      sel[3]  = CSR_WINDOW;
      data[0] = {(CSR_DATA_W-1)'($urandom), en};
      data[1] = {(CSR_DATA_W-RATE_W)'($urandom), rate};
      data[2] = {(CSR_DATA_W-RATE_W)'($urandom), burst};
      data[3] = CSR_DATA_W'(win_ms);
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= sel[i];
         csr_wdata <= data[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_enabled   = en;
      cfg_rate      = rate;
      cfg_burst     = burst;
      cfg_window_ms = win_ms;
      settings_used++;
   endtask

   // request driver
   always @(negedge clock) begin
      request_word_type w;
      if (!req_if.valid || req_taken) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            w = pending_requests.pop_front();
            req_if.valid      <= 1'b1;
            req_if.operation  <= w.op;
            req_if.client_key <= w.key;
            req_if.now_ns     <= w.now;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: predict on request accept, compare on result accept
   always @(posedge clock) begin
      request_word_type w;
      verdict_word_type want;
      req_taken = req_if.valid && req_if.ready && !reset;
      if (req_taken) begin
         w.op  = op_type'(req_if.operation);
         w.key = req_if.client_key;
         w.now = req_if.now_ns;
         want  = judge_request(w);
         expected_verdicts.push_back(want);
         words_seen++;
         if (w.op == OP_CHECK && want.verdict == VERDICT_DENIED) denied_seen++;
         if (w.op == OP_CLEANUP) begin
            sweeps_seen++;
            removed_seen += want.removed;
         end
      end
      if (rsp_if.valid && rsp_if.ready && !reset) begin
         if (expected_verdicts.size() == 0) begin
            $error("result word with nothing outstanding: verdict %0d count %0d removed %0d",
                   rsp_if.verdict, rsp_if.window_count, rsp_if.removed_entries);
            mismatches++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_if.verdict !== want.verdict) begin
               $error("verdict: expected %0d, got %0d", want.verdict, rsp_if.verdict);
               mismatches++;
            end
            if (rsp_if.window_count !== want.count) begin
               $error("window_count: expected %0d, got %0d", want.count, rsp_if.window_count);
               mismatches++;
            end
            if (rsp_if.removed_entries !== want.removed) begin
               $error("removed_entries: expected %0d, got %0d",
                      want.removed, rsp_if.removed_entries);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int                   kind;
      int                   pick;
      int                   random_start;
      logic [KEY_W-1:0]     group[$];
      logic [KEY_W-1:0]     key;
      logic [TIME_W-1:0]    span;
      logic [TIME_W-1:0]    t0;
      op_type               op;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_ENABLED;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.operation  = OP_CHECK;
      req_if.client_key = '0;
      req_if.now_ns     = '0;
      rsp_if.ready      = 1'b0;
      req_taken         = 1'b0;
      mismatches        = 0;
      cycles            = 0;
      words_queued      = 0;
      words_seen        = 0;
      settings_used     = 0;
      denied_seen       = 0;
      sweeps_seen       = 0;
      removed_seen      = 0;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      cfg_enabled       = RST_ENABLED;
      cfg_rate          = RST_RATE;
      cfg_burst         = RST_BURST;
      cfg_window_ms     = RST_WINDOW_MS;
      send_idle_pct     = 8;
      recv_idle_pct     = 54;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: lookups, wrapping elapsed time, window boundary, sweeps
      queue_word(OP_CHECK, '0, '0);
      queue_word(OP_CHECK, '1, '1 - 64'd15);
      queue_word(OP_CHECK, '1, 64'd16);
      queue_word(OP_QUERY, '0, 64'd20);
      queue_word(OP_QUERY, 32'h1234_5678, 64'd20);
      queue_word(OP_RESET, '0, 64'd5);
      queue_word(OP_RESET, 32'h1234_5678, 64'd5);
      queue_word(OP_QUERY, '0, 64'd6);
      queue_word(OP_CHECK, '0, 64'd1_000_000_005);   // elapsed equals window: no restart
      queue_word(OP_CHECK, '0, 64'd1_000_000_006);   // one past: window restarts
      queue_word(OP_CLEANUP, '0, 64'd2_000_000_000);
      queue_word(OP_CLEANUP, '1, 64'd5_000_000_000);
      drain();

      // disabled limiter
      apply_settings(1'b0, RST_RATE, RST_BURST, RST_WINDOW_MS);
      queue_word(OP_CHECK, 32'd7, 64'd6_000_000_000);
      queue_word(OP_QUERY, 32'd7, 64'd6_000_000_000);
      queue_word(OP_RESET, 32'd7, 64'd6_000_000_000);
      queue_word(OP_CLEANUP, 32'd7, 64'd6_000_000_000);
      drain();

      // zero allowance
      apply_settings(1'b1, '0, '0, RST_WINDOW_MS);
      queue_word(OP_CHECK, 32'd9, 64'd6_000_000_000);
      queue_word(OP_QUERY, 32'd9, 64'd6_000_000_000);
      drain();

      // limit of two with a zero window
      apply_settings(1'b1, 16'd1, 16'd1, '0);
      t0 = 64'd6_000_000_100;
      queue_word(OP_CHECK, 32'hA5A5_5A5A, t0);
      queue_word(OP_CHECK, 32'hA5A5_5A5A, t0);
      queue_word(OP_CHECK, 32'hA5A5_5A5A, t0);
      queue_word(OP_CHECK, 32'hA5A5_5A5A, t0 + 1);
      queue_word(OP_CLEANUP, '0, t0 + 1);
      clock_ns = t0 + 1;

      random_start = words_queued;
      while (words_queued - random_start < RANDOM_WORDS) begin
         drain();
         if (words_queued - random_start >= 2 * RANDOM_WORDS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (words_queued - random_start >= RANDOM_WORDS / 3) begin
            send_idle_pct = 54;
            recv_idle_pct = 8;
         end
         kind = $urandom_range(9);
         apply_settings((kind >= 5 && kind <= 6) || $urandom_range(9) != 0,
                        pick_allowance(), pick_allowance(),
                        ($urandom_range(4) == 0) ? WIN_MS_W'(0) :
                        ($urandom_range(3) == 0) ? WIN_MS_W'($urandom_range(1, 20)) :
                        ($urandom_range(2) == 0) ? '1 : WIN_MS_W'($urandom));
         span = window_in_ns();
         if (kind <= 4) begin
            // traffic from a small group of clients
            group.delete();
            repeat ($urandom_range(1, 6))
               group.push_back((key_pool.size() > 0 && $urandom_range(1) == 1) ?
                               key_pool[$urandom_range(key_pool.size() - 1)] : $urandom);
            if ($urandom_range(6) == 0) clock_ns = '1 - span - $urandom_range(0, 2000);
            repeat ($urandom_range(40, 90)) begin
               clock_ns = clock_ns + time_step();
               pick     = $urandom_range(99);
               op       = (pick < 75) ? OP_CHECK : (pick < 83) ? OP_RESET :
                          (pick < 93) ? OP_QUERY : OP_CLEANUP;
               key      = ($urandom_range(19) == 0) ? $urandom :
                          group[$urandom_range(group.size() - 1)];
               queue_word(op, key, clock_ns);
            end
         end else if (kind <= 6) begin
            // fill the table past capacity, then sweep it
            repeat ($urandom_range(66, 72)) begin
               clock_ns = clock_ns + $urandom_range(0, 3);
               queue_word(OP_CHECK, $urandom, clock_ns);
            end
            queue_word(OP_QUERY, key_pool[$], clock_ns);
            clock_ns = clock_ns + (span << 1) + 1 + $urandom_range(0, 50);
            queue_word(OP_CLEANUP, $urandom, clock_ns);
            repeat ($urandom_range(3, 8)) queue_word(OP_CHECK, $urandom, clock_ns);
         end else begin
            // unordered words: any operation, stray keys, time jumping back and forth
            repeat ($urandom_range(20, 40)) begin
               op  = op_type'($urandom_range(3));
               key = ($urandom_range(1) == 0 || key_pool.size() == 0) ? $urandom :
                     key_pool[$urandom_range(key_pool.size() - 1)];
               case ($urandom_range(2))
                  0:       queue_word(op, key, {$urandom, $urandom});
                  1:       queue_word(op, key, clock_ns - $urandom_range(0, 1000));
                  default: begin
                     clock_ns = clock_ns + time_step();
                     queue_word(op, key, clock_ns);
                  end
               endcase
            end
         end
      end
      drain();

      $display("Covered %0d request words under %0d register settings",
               words_seen, settings_used);
      $display("%0d checks denied, %0d cleanup sweeps freeing %0d clients",
               denied_seen, sweeps_seen, removed_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/pcwrl_pkg.sv
hw/rtl/pcwrl_req_if.sv
hw/rtl/pcwrl_rsp_if.sv
hw/rtl/pcwrl_ctrl.sv
hw/rtl/pcwrl_dpath.sv
hw/rtl/per_client_window_rate_limiter.sv
dv/per_client_window_rate_limiter_tb.sv
